// ----- rtl/core/bblru_pkg.sv -----
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared constants, codes and control types of the byte-budget LRU directory.
// ----------------------------------------------------------------------------
package bblru_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(ENTRIES);

    localparam int TOTAL_W  = 36;
    localparam int LEN_W    = 32;
    localparam int STAMP_W  = 32;
    localparam int KEYIO_W  = 32;
    localparam int RAM_W    = KEY_BITS + LEN_W + STAMP_W;

    localparam logic [TOTAL_W-1:0] LIMIT_RESET = TOTAL_W'(1048576);

    // Input command codes.
    localparam logic [1:0] CMD_STORE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_FIT    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_REFUSED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_HIT     = 3'd3;
    localparam logic [2:0] ST_MISS    = 3'd4;
    localparam logic [2:0] ST_EVICTED = 3'd5;
    localparam logic [2:0] ST_WITHIN  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic act_fire;
        logic direct;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       cacheable;
        logic       over;
        logic       scan_done;
        logic       out_free;
        logic       evict_more;
    } t_dp_stat;

endpackage

// ----- rtl/core/bblru_ram.sv -----
// ----------------------------------------------------------------------------
// bblru_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bblru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bblru_ctrl.sv -----
// ----------------------------------------------------------------------------
// bblru_ctrl
// Sequencer: takes one item, runs table scans and fires each result.
// ----------------------------------------------------------------------------
module bblru_ctrl
    import bblru_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd,
    output logic      o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_DISPATCH = 4'b0010,
        S_SCAN     = 4'b0100,
        S_ACT      = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_direct, n_direct;

    always_comb begin
        n_state  = r_state;
        n_direct = r_direct;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_direct = 1'b0;
                case (i_stat.cmd)
                    CMD_STORE: begin
                        if (!i_stat.cacheable) begin
                            n_direct = 1'b1;
                            n_state  = S_ACT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    CMD_LOOKUP: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    CMD_FIT: begin
                        if (!i_stat.over) begin
                            n_direct = 1'b1;
                            n_state  = S_ACT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                o_cmd.direct = r_direct;
                if (i_stat.out_free) begin
                    o_cmd.act_fire = 1'b1;
                    if (i_stat.evict_more) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_direct <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_direct <= n_direct;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/core/bblru_dp.sv -----
// ----------------------------------------------------------------------------
// bblru_dp
// Datapath: entry table, scan unit, byte total, access clock, result register.
// ----------------------------------------------------------------------------
module bblru_dp
    import bblru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_data,
    input  logic [1:0]         i_cmd_in,
    input  logic [KEYIO_W-1:0] i_key,
    input  logic [LEN_W-1:0]   i_body_bytes,
    input  logic               i_cacheable,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [2:0]         o_status,
    output logic [KEYIO_W-1:0] o_key_out,
    output logic [TOTAL_W-1:0] o_total_bytes,
    output logic               o_last
);

    function automatic logic [KEY_BITS-1:0] key_fit(input logic [KEYIO_W-1:0] k);
        logic [KEY_BITS+KEYIO_W-1:0] t;
        t = (KEY_BITS + KEYIO_W)'(k);
        return t[KEY_BITS-1:0];
    endfunction

    function automatic logic [KEYIO_W-1:0] key_out(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS+KEYIO_W-1:0] t;
        t = (KEY_BITS + KEYIO_W)'(k);
        return t[KEYIO_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] total_sub(input logic [TOTAL_W-1:0] t,
                                                     input logic [LEN_W-1:0]   n);
        logic [TOTAL_W-1:0] ne;
        ne = TOTAL_W'(n);
        return (ne > t) ? '0 : t - ne;
    endfunction

    function automatic logic [TOTAL_W-1:0] total_add(input logic [TOTAL_W-1:0] t,
                                                     input logic [LEN_W-1:0]   n);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + (TOTAL_W + 1)'(n);
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    // Captured input item.
    logic [1:0]          r_cmd;
    logic [KEYIO_W-1:0]  r_key_in;
    logic [LEN_W-1:0]    r_len_in;
    logic                r_cacheable;

    // Architectural state.
    logic [TOTAL_W-1:0]  r_limit;
    logic [TOTAL_W-1:0]  r_total;
    logic [STAMP_W-1:0]  r_clock;
    logic [ENTRIES-1:0]  r_valid;

    // Scan unit.
    logic [IDX_W-1:0]    r_scan_idx;
    logic                r_scan_run;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;

    logic                r_match_found;
    logic [IDX_W-1:0]    r_match_idx;
    logic [LEN_W-1:0]    r_match_len;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_old_found;
    logic [IDX_W-1:0]    r_old_idx;
    logic [STAMP_W-1:0]  r_old_age;
    logic [KEY_BITS-1:0] r_old_key;
    logic [LEN_W-1:0]    r_old_len;

    // Result register.
    logic                r_out_valid;
    logic [2:0]          r_status;
    logic [KEYIO_W-1:0]  r_key_out;
    logic [TOTAL_W-1:0]  r_total_out;
    logic                r_last;

    logic [RAM_W-1:0]    ram_rdata;
    logic [RAM_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_waddr;
    logic                ram_we;

    logic [KEY_BITS-1:0] e_key;
    logic [LEN_W-1:0]    e_len;
    logic [STAMP_W-1:0]  e_stamp;
    logic [STAMP_W-1:0]  e_age;
    logic                e_valid;
    logic                e_match;
    logic [KEY_BITS-1:0] in_key;
    logic                out_free;

    logic [2:0]          act_status;
    logic [KEYIO_W-1:0]  act_key;
    logic                act_last;
    logic [TOTAL_W-1:0]  act_total;
    logic                act_clock_inc;
    logic                act_set_valid;
    logic                act_clr_valid;
    logic                act_more;
    logic [TOTAL_W-1:0]  store_total;
    logic [TOTAL_W-1:0]  evict_total;
    logic [ENTRIES-1:0]  rest_valid;
    logic                evict_done;

    assign in_key   = key_fit(r_key_in);
    assign e_key    = ram_rdata[RAM_W-1 -: KEY_BITS];
    assign e_len    = ram_rdata[STAMP_W +: LEN_W];
    assign e_stamp  = ram_rdata[STAMP_W-1:0];
    assign e_age    = r_clock - e_stamp;
    assign e_valid  = r_valid[r_cmp_idx];
    assign e_match  = e_valid && (e_key == in_key);
    assign out_free = !r_out_valid || !i_out_stall;

    bblru_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (ram_rdata)
    );

    // Result of the current action, from the scan findings.
    always_comb begin
        store_total = total_add(r_match_found ? total_sub(r_total, r_match_len) : r_total,
                                r_len_in);
        evict_total = total_sub(r_total, r_old_len);
        rest_valid  = r_valid;
        rest_valid[r_old_idx] = 1'b0;
        evict_done  = (evict_total < r_limit) || (rest_valid == '0);

        act_status    = ST_WITHIN;
        act_key       = r_key_in;
        act_last      = 1'b1;
        act_total     = r_total;
        act_clock_inc = 1'b0;
        act_set_valid = 1'b0;
        act_clr_valid = 1'b0;
        act_more      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_match_found ? r_match_idx : r_free_idx;
        ram_wdata     = {in_key, r_match_found ? r_match_len : r_len_in, r_clock};

        case (r_cmd)
            CMD_STORE: begin
                ram_wdata = {in_key, r_len_in, r_clock};
                if (i_cmd.direct) begin
                    act_status = ST_REFUSED;
                end else if (r_match_found || r_free_found) begin
                    act_status    = ST_STORED;
                    act_total     = store_total;
                    act_clock_inc = 1'b1;
                    act_set_valid = !r_match_found;
                    ram_we        = 1'b1;
                end else begin
                    act_status = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                if (r_match_found) begin
                    act_status    = ST_HIT;
                    act_clock_inc = 1'b1;
                    ram_we        = 1'b1;
                end else begin
                    act_status = ST_MISS;
                end
            end
            CMD_FIT: begin
                if (!i_cmd.direct && r_old_found) begin
                    act_status    = ST_EVICTED;
                    act_key       = key_out(r_old_key);
                    act_total     = evict_total;
                    act_clr_valid = 1'b1;
                    act_last      = evict_done;
                    act_more      = !evict_done;
                end
            end
            default: begin
                act_status = ST_WITHIN;
            end
        endcase

        ram_we = ram_we && i_cmd.act_fire;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= LIMIT_RESET;
            r_total       <= '0;
            r_clock       <= '0;
            r_valid       <= '0;
            r_scan_run    <= 1'b0;
            r_cmp_vld     <= 1'b0;
            r_scan_idx    <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_old_found   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end

            r_cmp_vld <= r_scan_run;
            if (i_cmd.scan_start) begin
                r_scan_run    <= 1'b1;
                r_scan_idx    <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
                r_old_found   <= 1'b0;
            end else begin
                if (r_scan_run) begin
                    if (r_scan_idx == IDX_W'(ENTRIES - 1)) begin
                        r_scan_run <= 1'b0;
                    end else begin
                        r_scan_idx <= r_scan_idx + IDX_W'(1);
                    end
                end
                if (r_cmp_vld) begin
                    if (e_match && !r_match_found) begin
                        r_match_found <= 1'b1;
                    end
                    if (!e_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                    if (e_valid && (!r_old_found || e_age > r_old_age)) begin
                        r_old_found <= 1'b1;
                    end
                end
            end

            if (i_cmd.act_fire) begin
                r_total <= act_total;
                if (act_clock_inc) begin
                    r_clock <= r_clock + STAMP_W'(1);
                end
                if (act_set_valid) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (act_clr_valid) begin
                    r_valid[r_old_idx] <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd       <= i_cmd_in;
            r_key_in    <= i_key;
            r_len_in    <= i_body_bytes;
            r_cacheable <= i_cacheable;
        end
        if (r_scan_run) begin
            r_cmp_idx <= r_scan_idx;
        end
        if (r_cmp_vld && !i_cmd.scan_start) begin
            if (e_match && !r_match_found) begin
                r_match_idx <= r_cmp_idx;
                r_match_len <= e_len;
            end
            if (!e_valid && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
            if (e_valid && (!r_old_found || e_age > r_old_age)) begin
                r_old_idx <= r_cmp_idx;
                r_old_age <= e_age;
                r_old_key <= e_key;
                r_old_len <= e_len;
            end
        end
        if (i_cmd.act_fire) begin
            r_status    <= act_status;
            r_key_out   <= act_key;
            r_total_out <= act_total;
            r_last      <= act_last;
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.cacheable  = r_cacheable;
    assign o_stat.over       = (r_total > r_limit);
    assign o_stat.scan_done  = r_cmp_vld && (r_cmp_idx == IDX_W'(ENTRIES - 1));
    assign o_stat.out_free   = out_free;
    assign o_stat.evict_more = act_more;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_key_out     = r_key_out;
    assign o_total_bytes = r_total_out;
    assign o_last        = r_last;

endmodule

// ----- rtl/core/byte_budget_lru_cache_directory.sv -----
// A store or lookup gives its result after a full table scan; a refused store or a fit
// within the limit gives it without a scan. The block takes one item at a time, and a
// fit runs a further scan for each further eviction. The table scan reads the RAM at
// one entry per cycle.
// Reset (synchronous, active low) empties the table, clears the byte total and the
// access clock, and sets the byte limit to 1 MiB.
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_directory
// Size-aware LRU directory of cached objects with a byte budget and eviction.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_directory
    import bblru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // Byte limit register.
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_data,

    // Input item channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [KEYIO_W-1:0] i_key,
    input  logic [LEN_W-1:0]   i_body_bytes,
    input  logic               i_cacheable,

    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [KEYIO_W-1:0] o_key_out,
    output logic [TOTAL_W-1:0] o_total_bytes,
    output logic               o_last
);

    // The controller takes one input transfer at a time. Every store, lookup
    // and fit that needs the table walks all entries through the RAM read
    // port, one per cycle, and the datapath collects the first key match, the
    // first free slot and the oldest valid entry along the way. The action
    // that follows updates the table, the byte total and the access clock and
    // loads the result register, all in the same cycle. A fit whose total is
    // not yet below the limit after an eviction, with entries left, starts a
    // new walk for the next oldest entry. The result register lets a new input
    // transfer be taken while a result is still waiting on the output side.

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    bblru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd),
        .o_in_stall (o_in_stall)
    );

    bblru_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_in      (i_cmd),
        .i_key         (i_key),
        .i_body_bytes  (i_body_bytes),
        .i_cacheable   (i_cacheable),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_total_bytes (o_total_bytes),
        .o_last        (o_last)
    );

endmodule

// ----- rtl/core/bblru_chk.sv -----
// ----------------------------------------------------------------------------
// bblru_chk
// Port-level checks of the directory, bound to the top level.
// ----------------------------------------------------------------------------
module bblru_chk
    import bblru_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic [KEYIO_W-1:0] o_key_out,
    input logic [TOTAL_W-1:0] o_total_bytes,
    input logic               o_last
);

    // A waiting result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_key_out) && $stable(o_total_bytes) && $stable(o_last)))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while busy");

    // Only known status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_WITHIN))
        else $error("unknown status code");

    // Every result other than an eviction is the only one of its item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_EVICTED)) |-> o_last)
        else $error("non-eviction result not marked last");

endmodule

bind byte_budget_lru_cache_directory bblru_chk u_bblru_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_key_out     (o_key_out),
    .o_total_bytes (o_total_bytes),
    .o_last        (o_last)
);
